FILE: sv/rtoc_pkg.sv
// Shared constants and types of the region table overlap checker.
package rtoc_pkg;

  localparam int REGION_SLOTS = 64;
  localparam int SLOT_W = (REGION_SLOTS > 1) ? $clog2(REGION_SLOTS) : 1;
  localparam int CNT_W = $clog2(REGION_SLOTS + 1);
  localparam int ADDR_W = 64;
  localparam int CFG_W = 7;
  localparam int OUT_SLOT_W = 6;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_OVERLAP = 2'd1,
    REQ_CONTAIN = 2'd2,
    REQ_REMAIN  = 2'd3
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
  } region_t;

  typedef struct packed {
    req_t              req;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] len;
    logic [ADDR_W-1:0] stop;
  } query_t;

  typedef struct packed {
    logic              hit;
    logic [ADDR_W-1:0] offset;
  } cmp_t;

endpackage

FILE: sv/region_table_overlap_checker_top.sv
// Top level of the region table overlap checker: sequencer, table and compare unit.
// A table write goes from idle straight to the done state, which raises the result strobe.
// A query scans the table and goes to done on a miss (straight to done at a zero count),
// or via the calc state on a hit; a wrapping overlap or containment range skips the scan.
// One slot per cycle goes through the shared compare unit; busy stays high through the strobe
// cycle, so the next transfer is taken on the edge after it, and the receiver cannot stall.
// Reset clears the scan count, the sequencer and every table slot to empty.
module region_table_overlap_checker_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [1:0]                         in_req_type,
  input  logic [5:0]                         in_slot,
  input  logic [rtoc_pkg::ADDR_W-1:0]        in_addr,
  input  logic [rtoc_pkg::ADDR_W-1:0]        in_len,
  output logic                               out_valid,
  output logic                               out_hit,
  output logic [rtoc_pkg::ADDR_W-1:0]        out_remaining_bytes,
  output logic [rtoc_pkg::OUT_SLOT_W-1:0]    out_match_slot,
  output logic [rtoc_pkg::ADDR_W-1:0]        out_match_start,
  output logic [rtoc_pkg::ADDR_W-1:0]        out_match_size,
  output logic                               out_status,
  input  logic                               cfg_we,
  input  logic [rtoc_pkg::CFG_W-1:0]         cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_DONE
  } state_t;

  state_t                             state_r;
  logic [rtoc_pkg::CFG_W-1:0]         entries_r;
  logic [rtoc_pkg::CNT_W-1:0]         scan_n_r;
  logic [rtoc_pkg::CNT_W-1:0]         rd_idx_r;
  logic                               pend_r;
  rtoc_pkg::query_t                   query_r;
  logic [rtoc_pkg::ADDR_W-1:0]        off_r;

  logic                               hit_r;
  logic [rtoc_pkg::ADDR_W-1:0]        remain_r;
  logic [rtoc_pkg::OUT_SLOT_W-1:0]    mslot_r;
  logic [rtoc_pkg::ADDR_W-1:0]        mstart_r;
  logic [rtoc_pkg::ADDR_W-1:0]        msize_r;
  logic                               status_r;

  logic                               accept;
  rtoc_pkg::req_t                     in_req;
  logic [rtoc_pkg::ADDR_W:0]          sum;
  logic                               wraps;
  logic [rtoc_pkg::CNT_W-1:0]         scan_n;
  logic                               wr_en;
  rtoc_pkg::region_t                  wr_data;
  rtoc_pkg::region_t                  rd_data;
  rtoc_pkg::cmp_t                     cmp;
  logic [rtoc_pkg::CNT_W-1:0]         cmp_idx;
  logic                               scan_last;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign in_req    = rtoc_pkg::req_t'(in_req_type);
  assign out_valid = (state_r == S_DONE);

  // The carry out of addr + len marks a range that runs past the top of memory.
  assign sum   = {1'b0, in_addr} + {1'b0, in_len};
  assign wraps = sum[rtoc_pkg::ADDR_W];

  // A scan count above the table depth scans the whole table.
  always_comb begin
    if (int'(entries_r) > rtoc_pkg::REGION_SLOTS) begin
      scan_n = rtoc_pkg::CNT_W'(rtoc_pkg::REGION_SLOTS);
    end else begin
      scan_n = rtoc_pkg::CNT_W'(entries_r);
    end
  end

  // Writes go straight into the table on the accepting edge.
  assign wr_en         = accept && (in_req == rtoc_pkg::REQ_WRITE)
                         && (int'(in_slot) < rtoc_pkg::REGION_SLOTS);
  assign wr_data.start = in_addr;
  assign wr_data.size  = in_len;

  rtoc_table u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_idx  (rtoc_pkg::SLOT_W'(in_slot)),
    .wr_data (wr_data),
    .rd_idx  (rd_idx_r[rtoc_pkg::SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  rtoc_match u_match (
    .query  (query_r),
    .region (rd_data),
    .result (cmp)
  );

  // The read issued last cycle is the slot being compared now.
  assign cmp_idx   = rd_idx_r - rtoc_pkg::CNT_W'(1);
  assign scan_last = (rd_idx_r == scan_n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      entries_r <= '0;
      pend_r    <= 1'b0;
      rd_idx_r  <= '0;
    end else begin
      if (cfg_we) begin
        entries_r <= cfg_wdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            query_r.req  <= in_req;
            query_r.addr <= in_addr;
            query_r.len  <= in_len;
            query_r.stop <= sum[rtoc_pkg::ADDR_W-1:0];
            scan_n_r     <= scan_n;
            rd_idx_r     <= '0;
            pend_r       <= 1'b0;
            hit_r        <= 1'b0;
            remain_r     <= '0;
            mslot_r      <= '0;
            mstart_r     <= '0;
            msize_r      <= '0;
            status_r     <= 1'b0;
            if (in_req == rtoc_pkg::REQ_WRITE) begin
              state_r <= S_DONE;
            end else if (wraps && (in_req == rtoc_pkg::REQ_OVERLAP ||
                                   in_req == rtoc_pkg::REQ_CONTAIN)) begin
              // A wrapping overlap range is a hit, a wrapping containment range a miss, neither with a slot.
              hit_r    <= (in_req == rtoc_pkg::REQ_OVERLAP);
              status_r <= 1'b1;
              state_r  <= S_DONE;
            end else if (scan_n == '0) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_idx_r <= rd_idx_r + rtoc_pkg::CNT_W'(1);
          pend_r   <= 1'b1;
          if (pend_r) begin
            if (cmp.hit) begin
              hit_r    <= 1'b1;
              mslot_r  <= rtoc_pkg::OUT_SLOT_W'(cmp_idx);
              mstart_r <= rd_data.start;
              msize_r  <= rd_data.size;
              off_r    <= cmp.offset;
              state_r  <= S_CALC;
            end else if (scan_last) begin
              state_r <= S_DONE;
            end
          end
        end
        S_CALC: begin
          // The remaining-bytes answer reuses the offset taken at the match.
          if (query_r.req == rtoc_pkg::REQ_REMAIN) begin
            remain_r <= msize_r - off_r;
          end
          state_r <= S_DONE;
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_hit             = hit_r;
  assign out_remaining_bytes = remain_r;
  assign out_match_slot      = mslot_r;
  assign out_match_start     = mstart_r;
  assign out_match_size      = msize_r;
  assign out_status          = status_r;

  // Each request yields a single result cycle before the block frees up.
  a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe lasted more than one cycle");

  // The scan pointer never runs past the scan count while comparing.
  a_scan_bound : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && pend_r) |-> (rd_idx_r <= scan_n_r) && (rd_idx_r != '0))
    else $error("scan pointer ran past the scan count");

  // A wrapping range never reports a matched region.
  a_wrap_no_slot : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (out_match_size == '0 && out_remaining_bytes == '0))
    else $error("wrapping range reported a region");

  // A reported region is never empty.
  a_hit_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit && !out_status) |-> (out_match_size != '0))
    else $error("empty region reported as a match");

endmodule

FILE: sv/rtoc_table.sv
// Region table storage: one write port, one registered read port, valid bits.
module rtoc_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [rtoc_pkg::SLOT_W-1:0]  wr_idx,
  input  rtoc_pkg::region_t            wr_data,
  input  logic [rtoc_pkg::SLOT_W-1:0]  rd_idx,
  output rtoc_pkg::region_t            rd_data
);

  rtoc_pkg::region_t                    mem [rtoc_pkg::REGION_SLOTS];
  logic [rtoc_pkg::REGION_SLOTS-1:0]    valid_r;
  rtoc_pkg::region_t                    rd_data_r;
  logic                                 rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    rd_data_r <= mem[rd_idx];
  end

  // Entries never written read as an empty region at address zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      rd_valid_r <= valid_r[rd_idx];
    end
  end

  assign rd_data = rd_valid_r ? rd_data_r : '0;

endmodule

FILE: sv/rtoc_match.sv
// Compare unit: tests one region against the current query.
module rtoc_match (
  input  rtoc_pkg::query_t   query,
  input  rtoc_pkg::region_t  region,
  output rtoc_pkg::cmp_t     result
);

  logic [rtoc_pkg::ADDR_W-1:0] offset;
  logic [rtoc_pkg::ADDR_W-1:0] span;
  logic                        nonempty;
  logic                        at_or_above;
  logic                        in_region;
  logic                        below_end;
  logic                        m;

  assign offset      = query.addr - region.start;
  assign span        = query.stop - region.start;
  assign nonempty    = (region.size != '0);
  assign at_or_above = (query.addr >= region.start);
  assign in_region   = at_or_above && (offset < region.size);
  assign below_end   = !at_or_above || (offset < region.size);

  always_comb begin
    case (query.req)
      rtoc_pkg::REQ_OVERLAP: begin
        if (query.len == '0) begin
          m = in_region;
        end else begin
          m = below_end && (region.start < query.stop);
        end
      end
      rtoc_pkg::REQ_CONTAIN: m = at_or_above && (span <= region.size);
      rtoc_pkg::REQ_REMAIN:  m = in_region;
      default:               m = 1'b0;
    endcase
  end

  assign result.hit    = nonempty && m;
  assign result.offset = offset;

endmodule
